### sv/assert_macros.svh
// assertion macros shared by the classifier rtl
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### sv/nufc_pkg.sv
// shared types and codes for the nal unit frame classifier
// no dependencies; imported by every classifier module
package nufc_pkg;

   // default limit on exp-golomb leading zeros in one code
   localparam int MAX_PREFIX_ZEROS_DEF = 31;
   // default depth of the result queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // frame class codes
   localparam logic [2:0] CLASS_UNKNOWN = 3'd0;
   localparam logic [2:0] CLASS_P       = 3'd1;
   localparam logic [2:0] CLASS_B       = 3'd2;
   localparam logic [2:0] CLASS_I       = 3'd3;
   localparam logic [2:0] CLASS_SEI     = 3'd4;
   localparam logic [2:0] CLASS_SPS     = 3'd5;
   localparam logic [2:0] CLASS_PPS     = 3'd6;

   // nal unit type codes
   localparam logic [4:0] NAL_CODED_NONIDR = 5'd1;
   localparam logic [4:0] NAL_CODED_IDR    = 5'd5;
   localparam logic [4:0] NAL_SEI          = 5'd6;
   localparam logic [4:0] NAL_SPS          = 5'd7;
   localparam logic [4:0] NAL_PPS          = 5'd8;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_SECOND,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [2:0] frame_class;
      logic [4:0] unit_type;
      logic [1:0] reference_level;
      logic       forbidden_flag;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### sv/nufc_front.sv
// front end: accepts nal bytes, parses the header and exp-golomb codes
// depends on nufc_pkg and assert_macros.svh; pushes results into nufc_queue
`include "assert_macros.svh"

module nufc_front #(
   parameter int MAX_PREFIX_ZEROS = nufc_pkg::MAX_PREFIX_ZEROS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_first_byte,
   input  logic                      req_last_byte,
   input  nufc_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output nufc_pkg::result_type      push_data
);
   import nufc_pkg::*;

   localparam int ZR_W = $clog2(MAX_PREFIX_ZEROS + 1);
   localparam logic [ZR_W-1:0] ZR_MAX = ZR_W'(MAX_PREFIX_ZEROS);

   phase_type       phase_ff, phase_in;
   logic [ZR_W-1:0] zero_run_ff, zero_run_in;
   logic [ZR_W-1:0] suffix_ff, suffix_in;
   logic [3:0]      acc_ff, acc_in;
   logic            big_ff, big_in;
   logic [7:0]      header_ff, header_in;
   logic            accept;
   logic            emit;
   logic [2:0]      emit_class;

   function automatic logic [2:0] map_slice(input logic [3:0] v);
      logic [2:0] c;
      case (v) inside
         4'd0, 4'd3, 4'd5, 4'd8:  c = CLASS_P;
         4'd1, 4'd6:              c = CLASS_B;
         4'd2, 4'd4, 4'd7, 4'd9:  c = CLASS_I;
         default:                 c = CLASS_UNKNOWN;
      endcase
      return c;
   endfunction

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         zero_run_ff <= '0;
         suffix_ff   <= '0;
         acc_ff      <= '0;
         big_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         zero_run_ff <= zero_run_in;
         suffix_ff   <= suffix_in;
         acc_ff      <= acc_in;
         big_ff      <= big_in;
      end
      header_ff <= header_in;
   end

   always_comb begin
      logic       b;
      logic       code_done;
      logic [3:0] val;
      phase_in    = phase_ff;
      zero_run_in = zero_run_ff;
      suffix_in   = suffix_ff;
      acc_in      = acc_ff;
      big_in      = big_ff;
      header_in   = header_ff;
      emit        = 1'b0;
      emit_class  = CLASS_UNKNOWN;
      b           = 1'b0;
      code_done   = 1'b0;
      val         = '0;
      if (accept) begin
         if (req_first_byte) begin
            header_in   = req_data_byte;
            zero_run_in = '0;
            suffix_in   = '0;
            acc_in      = '0;
            big_in      = 1'b0;
            unique case (req_data_byte[4:0])
               NAL_CODED_NONIDR, NAL_CODED_IDR: phase_in = PH_FIRST;
               NAL_SEI: begin
                  emit = 1'b1; emit_class = CLASS_SEI; phase_in = PH_DONE;
               end
               NAL_SPS: begin
                  emit = 1'b1; emit_class = CLASS_SPS; phase_in = PH_DONE;
               end
               NAL_PPS: begin
                  emit = 1'b1; emit_class = CLASS_PPS; phase_in = PH_DONE;
               end
               default: begin
                  emit = 1'b1; emit_class = CLASS_UNKNOWN; phase_in = PH_DONE;
               end
            endcase
         end else if (phase_ff == PH_FIRST || phase_ff == PH_SECOND) begin
            // one exp-golomb bit step per data bit, msb first
            for (int i = 7; i >= 0; i--) begin
               if (!emit) begin
                  b         = req_data_byte[3'(i)];
                  code_done = 1'b0;
                  if (suffix_in != '0) begin
                     acc_in    = {acc_in[2:0], b};
                     suffix_in = suffix_in - ZR_W'(1);
                     if (suffix_in == '0) begin
                        code_done = 1'b1;
                        val       = acc_in - 4'd1;
                     end
                  end else if (!b) begin
                     if (zero_run_in >= ZR_MAX) begin
                        emit       = 1'b1;
                        emit_class = CLASS_UNKNOWN;
                        phase_in   = PH_DONE;
                     end else begin
                        zero_run_in = zero_run_in + ZR_W'(1);
                     end
                  end else if (zero_run_in == '0) begin
                     code_done = 1'b1;
                     val       = 4'd0;
                  end else begin
                     suffix_in = zero_run_in;
                     acc_in    = 4'd1;
                     // four or more prefix zeros give a value above nine
                     big_in    = zero_run_in > ZR_W'(3);
                  end
                  if (code_done) begin
                     if (phase_in == PH_FIRST) begin
                        phase_in    = PH_SECOND;
                        zero_run_in = '0;
                        suffix_in   = '0;
                        acc_in      = '0;
                        big_in      = 1'b0;
                     end else begin
                        emit       = 1'b1;
                        emit_class = big_in ? CLASS_UNKNOWN : map_slice(val);
                        phase_in   = PH_DONE;
                     end
                  end
               end
            end
         end
         if (req_last_byte && phase_in != PH_IDLE) begin
            // unit ends before its class is known
            if (phase_in == PH_FIRST || phase_in == PH_SECOND) begin
               emit       = 1'b1;
               emit_class = CLASS_UNKNOWN;
            end
            phase_in    = PH_IDLE;
            zero_run_in = '0;
            suffix_in   = '0;
            acc_in      = '0;
            big_in      = 1'b0;
         end
      end
   end

   assign push_valid                = emit;
   assign push_data.frame_class     = emit_class;
   assign push_data.unit_type       = header_in[4:0];
   assign push_data.reference_level = header_in[6:5];
   assign push_data.forbidden_flag  = header_in[7];

   `ASSERT_NEVER(a_push_needs_open_unit, clock, reset,
      push_valid && !req_first_byte && !(phase_ff == PH_FIRST || phase_ff == PH_SECOND),
      "result pushed for a unit that is not being parsed")
   `ASSERT_HOLDS(a_last_closes_unit, clock, reset,
      accept && req_last_byte |=> phase_ff == PH_IDLE,
      "unit still open after its last byte")

endmodule

### sv/nufc_queue.sv
// short result queue between the classifier front and back
// depends on nufc_pkg and assert_macros.svh
`include "assert_macros.svh"

module nufc_queue #(
   parameter int DEPTH = nufc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  nufc_pkg::result_type       push_data,
   input  logic                       pop,
   output nufc_pkg::result_type       pop_data,
   output nufc_pkg::queue_status_type status
);
   import nufc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   result_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = count_ff == FULL_CNT;
   assign status.empty = count_ff == '0;
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_no_push_when_full, clock, reset, push_valid && status.full,
      "result pushed into a full queue")
   `ASSERT_NEVER(a_no_pop_when_empty, clock, reset, pop && status.empty,
      "pop from an empty queue")
   `ASSERT_HOLDS(a_count_bounded, clock, reset, count_ff <= FULL_CNT,
      "queue count above depth")

endmodule

### sv/nufc_back.sv
// back end: output register that presents queued results on the rsp channel
// depends on nufc_pkg; pops nufc_queue
module nufc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  nufc_pkg::queue_status_type q_status,
   input  nufc_pkg::result_type       pop_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_frame_class,
   output logic [4:0]                 rsp_unit_type,
   output logic [1:0]                 rsp_reference_level,
   output logic                       rsp_forbidden_flag
);
   import nufc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // load a new word when the register is empty or its word is taken
   assign pop      = !q_status.empty && (!valid_ff || rsp_ready);
   assign valid_in = pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         result_ff <= pop_data;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_frame_class     = result_ff.frame_class;
   assign rsp_unit_type       = result_ff.unit_type;
   assign rsp_reference_level = result_ff.reference_level;
   assign rsp_forbidden_flag  = result_ff.forbidden_flag;

endmodule

### sv/nal_unit_frame_classifier_top.sv
// top level of the nal unit frame classifier
// depends on nufc_pkg, nufc_front, nufc_queue and nufc_back
//
//  channel | direction | fields                                        | handshake
//  req     | in        | data_byte[8] first_byte[1] last_byte[1]       | valid/ready
//  rsp     | out       | frame_class[3] unit_type[5] reference_level[2] | valid/ready
//                        forbidden_flag[1]
//
// one byte word is taken every cycle while the result queue is not full; the header split and up to eight
// exp-golomb bit steps of the byte are done in the front in that same cycle
// a result reaches rsp_valid through the queue write, then the output register
// reset is synchronous and active high, and leaves the block empty and ready
// req_ready drops only when the result queue is full; rsp stalls fill the queue
// and do not reach the front until then
module nal_unit_frame_classifier_top #(
   parameter int MAX_PREFIX_ZEROS = nufc_pkg::MAX_PREFIX_ZEROS_DEF,
   parameter int QUEUE_DEPTH      = nufc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_frame_class,
   output logic [4:0] rsp_unit_type,
   output logic [1:0] rsp_reference_level,
   output logic       rsp_forbidden_flag
);
   import nufc_pkg::*;

   // front to queue
   logic             push_valid;
   result_type       push_data;
   // queue to back
   logic             pop;
   result_type       pop_data;
   queue_status_type q_status;

   // parser: header split, slice-type exp-golomb decode, at most one result per unit
   nufc_front #(
      .MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_first_byte(req_first_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   // decoupling queue, lets the front keep parsing while rsp stalls
   nufc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // output register on the rsp channel
   nufc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop_data           (pop_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_class    (rsp_frame_class),
      .rsp_unit_type      (rsp_unit_type),
      .rsp_reference_level(rsp_reference_level),
      .rsp_forbidden_flag (rsp_forbidden_flag)
   );

endmodule

### dv/nufc_class_checker.sv
// checker for the nal unit frame classifier: watches both channels, predicts
// the class of every unit from the byte words taken in and compares results
// depends on nufc_pkg
module nufc_class_checker #(
   parameter int MAX_PREFIX_ZEROS = nufc_pkg::MAX_PREFIX_ZEROS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_frame_class,
   input  logic [4:0] rsp_unit_type,
   input  logic [1:0] rsp_reference_level,
   input  logic       rsp_forbidden_flag,
   input  logic       end_check,
   output int         error_count,
   output int         pending_count
);
   import nufc_pkg::*;

   typedef enum logic [1:0] {
      GOL_PENDING,
      GOL_DONE,
      GOL_OVERFLOW
   } golomb_step_type;

   // parser state of the predictor
   phase_type   phase;
   logic [5:0]  zeros;
   logic [5:0]  suffix_left;
   logic [31:0] code_acc;
   logic [7:0]  header;
   logic        reported;

   result_type  expected_classes[$];
   result_type  predicted;
   result_type  oldest;
   logic        produced;
   int          mismatches;
   logic        leftovers_counted;

   function automatic void clear_code();
      zeros       = '0;
      suffix_left = '0;
      code_acc    = '0;
   endfunction

   function automatic void report_class(input logic [2:0] cls, output result_type r);
      r.frame_class     = cls;
      r.unit_type       = header[4:0];
      r.reference_level = header[6:5];
      r.forbidden_flag  = header[7];
      reported = 1'b1;
      phase    = PH_DONE;
   endfunction

   // one bit into the unsigned exp-golomb decoder, msb first
   function automatic golomb_step_type golomb_bit(input logic b, output logic [31:0] value);
      value = '0;
      if (suffix_left != 0) begin
         code_acc    = {code_acc[30:0], b};
         suffix_left = suffix_left - 6'd1;
         if (suffix_left == 0) begin
            value = code_acc - 32'd1;
            return GOL_DONE;
         end
         return GOL_PENDING;
      end
      if (!b) begin
         if (zeros >= MAX_PREFIX_ZEROS)
            return GOL_OVERFLOW;
         zeros = zeros + 6'd1;
         return GOL_PENDING;
      end
      if (zeros == 0)
         return GOL_DONE;
      suffix_left = zeros;
      code_acc    = 32'd1;
      return GOL_PENDING;
   endfunction

   function automatic logic [2:0] slice_class(input logic [31:0] slice_type);
      case (slice_type)
         32'd0, 32'd3, 32'd5, 32'd8: return CLASS_P;
         32'd1, 32'd6:               return CLASS_B;
         32'd2, 32'd4, 32'd7, 32'd9: return CLASS_I;
         default:                    return CLASS_UNKNOWN;
      endcase
   endfunction

   function automatic void classify_word(input logic [7:0] data, input logic first,
                                         input logic last, output logic got,
                                         output result_type r);
      logic [4:0]      kind;
      logic [2:0]      cls;
      logic [31:0]     value;
      golomb_step_type step;
      got = 1'b0;
      r   = '0;
      if (first) begin
         kind     = data[4:0];
         header   = data;
         reported = 1'b0;
         clear_code();
         if (kind == NAL_CODED_NONIDR || kind == NAL_CODED_IDR) begin
            phase = PH_FIRST;
         end else begin
            case (kind)
               NAL_SEI: cls = CLASS_SEI;
               NAL_SPS: cls = CLASS_SPS;
               NAL_PPS: cls = CLASS_PPS;
               default: cls = CLASS_UNKNOWN;
            endcase
            report_class(cls, r);
            got = 1'b1;
         end
      end else if (phase == PH_FIRST || phase == PH_SECOND) begin
         for (int i = 7; i >= 0; i--) begin
            if (!got) begin
               step = golomb_bit(data[i], value);
               if (step == GOL_OVERFLOW) begin
                  report_class(CLASS_UNKNOWN, r);
                  got = 1'b1;
               end else if (step == GOL_DONE) begin
                  // first code is the macroblock address, only skipped
                  if (phase == PH_FIRST) begin
                     phase = PH_SECOND;
                     clear_code();
                  end else begin
                     report_class(slice_class(value), r);
                     got = 1'b1;
                  end
               end
            end
         end
      end
      if (last && phase != PH_IDLE) begin
         if (!reported) begin
            report_class(CLASS_UNKNOWN, r);
            got = 1'b1;
         end
         phase    = PH_IDLE;
         reported = 1'b1;
         clear_code();
      end
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase    = PH_IDLE;
         header   = '0;
         reported = 1'b1;
         clear_code();
         expected_classes.delete();
         mismatches        = 0;
         leftovers_counted = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_classes.size() == 0) begin
               $display("%0t: unexpected result, expected none actual class %0d type %0d",
                        $time, rsp_frame_class, rsp_unit_type);
               mismatches++;
            end else begin
               oldest = expected_classes.pop_front();
               check_field("frame_class", 8'(oldest.frame_class), 8'(rsp_frame_class));
               check_field("unit_type", 8'(oldest.unit_type), 8'(rsp_unit_type));
               check_field("reference_level", 8'(oldest.reference_level),
                           8'(rsp_reference_level));
               check_field("forbidden_flag", 8'(oldest.forbidden_flag),
                           8'(rsp_forbidden_flag));
            end
         end
         if (req_valid && req_ready) begin
            classify_word(req_data_byte, req_first_byte, req_last_byte, produced, predicted);
            if (produced)
               expected_classes.push_back(predicted);
         end
         if (end_check && !leftovers_counted) begin
            foreach (expected_classes[i])
               $display("%0t: missing result, expected class %0d type %0d actual none",
                        $time, expected_classes[i].frame_class, expected_classes[i].unit_type);
            mismatches += expected_classes.size();
            leftovers_counted = 1'b1;
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_classes.size();
   end

endmodule

### dv/tb_nal_unit_frame_classifier_top.sv
// testbench top for the nal unit frame classifier: drives nal units byte by
// byte with bursty valid and a stalling receiver, and gives the verdict
// depends on nufc_pkg, nufc_class_checker and the classifier rtl
module tb_nal_unit_frame_classifier_top;
   import nufc_pkg::*;

   // unit type with no class of its own
   localparam logic [4:0] NAL_UNSPECIFIED = 5'd0;
   // stimulus stops once this many byte words have been taken
   localparam int WORD_TARGET  = 650;
   // extra wait for margin after the last expected result has been taken
   localparam int DRAIN_CYCLES = 8;
   // far beyond the slowest legal run: every word waiting out a gap and
   // every result waiting out a long receiver stall
   localparam int RUN_LIMIT    = 200000;

   // how the receiver paces rsp_ready
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_BURSTY
   } ready_mode_type;

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte       = 8'h00;
   logic       req_first_byte      = 1'b0;
   logic       req_last_byte       = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready           = 1'b0;
   logic [2:0] rsp_frame_class;
   logic [4:0] rsp_unit_type;
   logic [1:0] rsp_reference_level;
   logic       rsp_forbidden_flag;

   logic       end_check = 1'b0;
   int         error_count;
   int         pending_count;

   // body of the next unit, and the exp-golomb bits it is built from
   logic [7:0] unit_body[$];
   logic       stream_bits[$];
   int         words_sent  = 0;
   int         burst_left  = 0;
   int         cycle_count = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;

   always #1 clock = ~clock;

   nal_unit_frame_classifier_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_first_byte      (req_first_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_class     (rsp_frame_class),
      .rsp_unit_type       (rsp_unit_type),
      .rsp_reference_level (rsp_reference_level),
      .rsp_forbidden_flag  (rsp_forbidden_flag)
   );

   nufc_class_checker #(
      .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS_DEF)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_first_byte      (req_first_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_class     (rsp_frame_class),
      .rsp_unit_type       (rsp_unit_type),
      .rsp_reference_level (rsp_reference_level),
      .rsp_forbidden_flag  (rsp_forbidden_flag),
      .end_check           (end_check),
      .error_count         (error_count),
      .pending_count       (pending_count)
   );

   // receiver: pacing mode is picked anew when its random run ends; the bursty mode
   // holds ready low long enough to fill the result queue and push back on req
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(20, 120);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= ((mode_left % 20) < 4);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("[nal_unit_frame_classifier_top] ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] header_of(input logic forbidden, input logic [1:0] ref_idc,
                                            input logic [4:0] kind);
      return {forbidden, ref_idc, kind};
   endfunction

   // exp-golomb code with lz leading zeros and the low lz bits of suffix
   function automatic void put_code(input int lz, input logic [31:0] suffix);
      repeat (lz) stream_bits.push_back(1'b0);
      stream_bits.push_back(1'b1);
      for (int k = lz - 1; k >= 0; k--)
         stream_bits.push_back(suffix[k]);
   endfunction

   // exp-golomb code of a small value
   function automatic void put_value(input int value);
      int lz;
      lz = 0;
      while (((value + 1) >> (lz + 1)) != 0)
         lz++;
      put_code(lz, value + 1 - (1 << lz));
   endfunction

   // prefix length, mostly short, now and then up to the limit
   function automatic int pick_zeros();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(0, 3);
      else if (pick < 95)
         return $urandom_range(4, 12);
      return $urandom_range(13, MAX_PREFIX_ZEROS_DEF);
   endfunction

   // pad the code bits with random bits to a whole byte, pack them into the
   // unit body and add random trailing bytes
   function automatic void pack_bits(input int trailing);
      logic [7:0] b;
      while (stream_bits.size() % 8 != 0)
         stream_bits.push_back(1'($urandom_range(0, 1)));
      while (stream_bits.size() > 0) begin
         for (int k = 7; k >= 0; k--)
            b[k] = stream_bits.pop_front();
         unit_body.push_back(b);
      end
      repeat (trailing) unit_body.push_back(8'($urandom_range(0, 255)));
   endfunction

   // one byte word; valid goes low only between bursts, never while a word waits
   task automatic send_word(input logic [7:0] data, input logic first, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left     = burst_left - 1;
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= first;
      req_last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // header then body; with close low the unit is left open for the next
   // header to drop
   task automatic send_unit(input logic [7:0] header, input logic close);
      int n;
      n = unit_body.size();
      send_word(header, 1'b1, close && n == 0);
      for (int k = 0; k < n; k++)
         send_word(unit_body[k], 1'b0, close && k == n - 1);
      unit_body.delete();
   endtask

   initial begin : stimulus
      int slice_types[6];
      int pick;
      int cut;
      int n;
      slice_types = '{0, 1, 2, 3, 4, 10};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // classes decided by the header alone, header is also the last byte
      send_unit(header_of(1'b1, 2'd3, NAL_SEI), 1'b1);
      send_unit(header_of(1'b0, 2'd3, NAL_SPS), 1'b1);
      send_unit(header_of(1'b0, 2'd0, NAL_PPS), 1'b1);
      send_unit(header_of(1'b1, 2'd0, NAL_UNSPECIFIED), 1'b1);

      // slice types p, b, i, sp, si and one past the mapped range
      for (int k = 0; k < 6; k++) begin
         put_value(0);
         put_value(slice_types[k]);
         pack_bits(0);
         send_unit(header_of(k == 5, 2'(k), (k % 2) ? NAL_CODED_IDR : NAL_CODED_NONIDR),
                   1'b1);
      end

      // slice header that is also the last byte
      send_unit(header_of(1'b0, 2'd1, NAL_CODED_IDR), 1'b1);
      // stray byte outside any unit, flagged last
      send_word(8'hFF, 1'b0, 1'b1);
      // prefix running past the limit in the first code
      repeat (4) unit_body.push_back(8'h00);
      send_unit(header_of(1'b0, 2'd2, NAL_CODED_NONIDR), 1'b1);
      // unit cut short by the next header, then a unit ending mid-code
      unit_body.push_back(8'h00);
      send_unit(header_of(1'b0, 2'd2, NAL_CODED_NONIDR), 1'b0);
      unit_body.push_back(8'h00);
      send_unit(header_of(1'b1, 2'd3, NAL_CODED_IDR), 1'b1);

      // random part: mostly well-formed slice units with random content
      while (words_sent < WORD_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            put_code(pick_zeros(), $urandom);
            if ($urandom_range(0, 6) != 0)
               put_value($urandom_range(0, 9));
            else
               put_code(pick_zeros(), $urandom);
            pack_bits($urandom_range(0, 3));
            // sometimes the unit ends before its codes are complete
            if ($urandom_range(0, 9) == 0) begin
               cut = $urandom_range(0, unit_body.size() - 1);
               while (unit_body.size() > cut)
                  unit_body.delete(unit_body.size() - 1);
            end
            send_unit(header_of($urandom_range(0, 7) == 0, 2'($urandom_range(0, 3)),
                                $urandom_range(0, 1) ? NAL_CODED_IDR : NAL_CODED_NONIDR),
                      $urandom_range(0, 19) != 0);
         end else if (pick < 70) begin
            repeat ($urandom_range(0, 3)) unit_body.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 2))
               0:       send_unit(header_of($urandom_range(0, 7) == 0,
                                            2'($urandom_range(0, 3)), NAL_SEI), 1'b1);
               1:       send_unit(header_of($urandom_range(0, 7) == 0,
                                            2'($urandom_range(0, 3)), NAL_SPS), 1'b1);
               default: send_unit(header_of($urandom_range(0, 7) == 0,
                                            2'($urandom_range(0, 3)), NAL_PPS), 1'b1);
            endcase
         end else if (pick < 80) begin
            repeat ($urandom_range(0, 4)) unit_body.push_back(8'($urandom_range(0, 255)));
            send_unit(header_of(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                5'($urandom_range(0, 31))), 1'b1);
         end else if (pick < 88) begin
            // long prefix near or past the limit, in either code
            if ($urandom_range(0, 1))
               put_value($urandom_range(0, 9));
            n = $urandom_range(24, 40);
            if (n <= MAX_PREFIX_ZEROS_DEF)
               put_code(n, $urandom);
            else
               repeat (n) stream_bits.push_back(1'b0);
            pack_bits($urandom_range(0, 2));
            send_unit(header_of($urandom_range(0, 7) == 0, 2'($urandom_range(0, 3)),
                                $urandom_range(0, 1) ? NAL_CODED_IDR : NAL_CODED_NONIDR),
                      1'b1);
         end else if (pick < 94) begin
            // noise words with no header in front
            repeat ($urandom_range(1, 3))
               send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(0, 6)) unit_body.push_back(8'($urandom_range(0, 255)));
            send_unit(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
         end
      end

      // drop valid right after the last word; the checker count is registered and lags behind
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0)
         $display("[nal_unit_frame_classifier_top] OK");
      else
         $display("[nal_unit_frame_classifier_top] ERROR");
      $finish;
   end

endmodule
